/* rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// opcodes, run states and stop causes of the stack machine executor
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

	localparam logic [7:0] OP_BREAK = 8'd0;
	localparam logic [7:0] OP_NOP   = 8'd1;
	localparam logic [7:0] OP_HALT  = 8'd2;
	localparam logic [7:0] OP_PUSH  = 8'd3;
	localparam logic [7:0] OP_PRINT = 8'd4;
	localparam logic [7:0] OP_JNE   = 8'd5;
	localparam logic [7:0] OP_SWAP  = 8'd6;
	localparam logic [7:0] OP_DUP   = 8'd7;
	localparam logic [7:0] OP_JE    = 8'd8;
	localparam logic [7:0] OP_INC   = 8'd9;
	localparam logic [7:0] OP_ADD   = 8'd10;
	localparam logic [7:0] OP_SUB   = 8'd11;
	localparam logic [7:0] OP_MUL   = 8'd12;
	localparam logic [7:0] OP_RAND  = 8'd13;
	localparam logic [7:0] OP_DEC   = 8'd14;
	localparam logic [7:0] OP_DROP  = 8'd15;
	localparam logic [7:0] OP_OVER  = 8'd16;
	localparam logic [7:0] OP_MOD   = 8'd17;
	localparam logic [7:0] OP_JUMP  = 8'd18;

	localparam logic [1:0] RS_RUN  = 2'd0;
	localparam logic [1:0] RS_HALT = 2'd1;
	localparam logic [1:0] RS_BRK  = 2'd2;

	localparam logic [2:0] SC_NONE  = 3'd0;
	localparam logic [2:0] SC_OVF   = 3'd1;
	localparam logic [2:0] SC_UNF   = 3'd2;
	localparam logic [2:0] SC_ZDIV  = 3'd3;
	localparam logic [2:0] SC_PC    = 3'd4;
	localparam logic [2:0] SC_BRK   = 3'd5;
	localparam logic [2:0] SC_HALT  = 3'd6;
	localparam logic [2:0] SC_LIMIT = 3'd7;

	localparam int IN_W  = 72;
	localparam int OUT_W = 176;

	typedef logic [62:0] steps_t;
	typedef logic [31:0] word_t;

endpackage

`default_nettype wire

/* rtl/stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// executes one stack machine instruction per input item and reports state
// ----------------------------------------------------------------------------
// steps: idle, stack read, execute, iterate (mul and mod only), write one
//   stack word per push, done; a new item is taken only in idle. The stack
//   memory has a single read and a single write port and mul / mod iterate
//   one bit a cycle on a shared 34-bit adder
// reset: stack empty, pc 0, running, step count 0, step limit 2^63-1
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_unit
	import smx_pkg::*;
#(
	parameter int STACK_DEPTH   = 64,
	parameter int PROGRAM_WORDS = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [62:0]      cfg_data,     // step_limit
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,      // opcode, immediate, random_word
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,      // next_pc, run_state, stop_cause,
	                                            // stack_depth, top_value,
	                                            // print_value, executed_steps, pad
	output logic                  m_tuser       // print_valid
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [31:0] PW32   = 32'(PROGRAM_WORDS);
	localparam logic [31:0] PW32M1 = 32'(PROGRAM_WORDS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1  = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_ITER = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]    state_q;
	steps_t        limit_q;
	steps_t        steps_q;
	word_t         pc_q;
	logic [1:0]    mstate_q;
	logic [CW-1:0] count_q;
	word_t         top_q;

	logic [7:0]    op_q;
	word_t         imm_q;
	word_t         rnd_q;
	word_t         b_q;
	logic [2:0]    cause_q;
	logic          printed_q;
	word_t         pval_q;

	logic [CW-1:0] wbase_q;
	logic [1:0]    pushn_q;
	logic [1:0]    widx_q;
	word_t         v_q [3];

	word_t         acc_q;
	word_t         ma_q;
	word_t         mb_q;
	logic          is_mod_q;
	logic [4:0]    it_q;

	word_t         mem [STACK_DEPTH];
	word_t         rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	word_t         wdata;

	logic          out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic          out_user_q;

	// decode and step outcome
	logic [7:0]    op;
	logic          len2;
	logic [1:0]    npop;
	logic [1:0]    npush;
	word_t         v0;
	word_t         v1;
	word_t         v2;
	word_t         d;
	logic          running;
	logic          at_limit;
	logic          range_f;
	logic          active;
	logic          unf;
	logic          zdiv;
	logic          ovf;
	logic          fault;
	logic          use_iter;
	logic [CW-1:0] pops_done;
	logic [CW-1:0] c1;
	logic [CW:0]   room;
	logic [1:0]    push_done;
	logic [CW-1:0] count_new;
	word_t         top_new;
	word_t         pc_next;
	word_t         jmp_pc;
	steps_t        steps_inc;
	logic [CW-1:0] rd_m2;
	logic [CW-1:0] rd_m3;
	logic [CW-1:0] wsum;
	logic [CW+6:0] cnt_ext;

	// shared iteration unit
	logic [33:0]   ux;
	logic [33:0]   uy;
	logic [33:0]   usum;
	logic          usub;
	word_t         iter_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	assign d       = rdata_q;
	assign rd_m2   = count_q - CW'(2);
	assign rd_m3   = count_q - CW'(3);
	assign wsum    = wbase_q + CW'(widx_q);
	assign raddr   = (state_q == ST_IDLE) ? rd_m2[AW-1:0] : rd_m3[AW-1:0];
	assign we      = (state_q == ST_WR) && (widx_q < pushn_q);
	assign waddr   = wsum[AW-1:0];
	assign wdata   = v_q[widx_q];
	assign cnt_ext = {7'd0, count_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		op = (op_q > OP_JUMP) ? OP_BREAK : op_q;
		len2  = 1'b0;
		npop  = 2'd0;
		npush = 2'd0;
		v0 = top_q;
		v1 = top_q;
		v2 = top_q;
		unique case (op)
			OP_PUSH: begin
				len2 = 1'b1; npush = 2'd1; v0 = imm_q;
			end
			OP_PRINT, OP_DROP: begin
				npop = 2'd1;
			end
			OP_JNE, OP_JE: begin
				len2 = 1'b1; npop = 2'd1;
			end
			OP_JUMP: begin
				len2 = 1'b1;
			end
			OP_SWAP: begin
				npop = 2'd2; npush = 2'd2; v0 = top_q; v1 = b_q;
			end
			OP_DUP: begin
				npop = 2'd1; npush = 2'd2;
			end
			OP_INC: begin
				npop = 2'd1; npush = 2'd1; v0 = top_q + 32'd1;
			end
			OP_DEC: begin
				npop = 2'd1; npush = 2'd1; v0 = top_q - 32'd1;
			end
			OP_ADD: begin
				npop = 2'd2; npush = 2'd1; v0 = top_q + b_q;
			end
			OP_SUB: begin
				npop = 2'd2; npush = 2'd1; v0 = top_q - b_q;
			end
			OP_MUL, OP_MOD: begin
				npop = 2'd2; npush = 2'd1;
			end
			OP_RAND: begin
				npush = 2'd1; v0 = rnd_q;
			end
			OP_OVER: begin
				npop = 2'd2; npush = 2'd3; v0 = b_q; v1 = top_q; v2 = b_q;
			end
			default: begin
			end
		endcase

		running  = (mstate_q == RS_RUN);
		at_limit = (steps_q >= limit_q);
		range_f  = len2 ? (pc_q >= PW32M1) : (pc_q >= PW32);
		active   = running && !at_limit && !range_f;

		unf  = active && (count_q < CW'(npop));
		zdiv = active && !unf && (op == OP_MOD) && (b_q == 32'd0);
		pops_done = !active ? '0 : (unf ? count_q : CW'(npop));
		c1   = count_q - pops_done;
		room = (CW+1)'(STACK_DEPTH) - {1'b0, c1};
		ovf  = active && !unf && !zdiv && ((CW+1)'(npush) > room);
		if (!active || unf || zdiv) begin
			push_done = 2'd0;
		end else if (ovf) begin
			push_done = room[1:0];
		end else begin
			push_done = npush;
		end
		fault    = (running && !at_limit && range_f) || unf || zdiv || ovf;
		use_iter = active && !unf && !zdiv && ((op == OP_MUL) || (op == OP_MOD));
		count_new = c1 + CW'(push_done);

		if (push_done == 2'd3) begin
			top_new = v2;
		end else if (push_done == 2'd2) begin
			top_new = v1;
		end else if (push_done == 2'd1) begin
			top_new = v0;
		end else if (count_new == '0) begin
			top_new = 32'd0;
		end else if (pops_done == '0) begin
			top_new = top_q;
		end else if (pops_done == CW'(1)) begin
			top_new = b_q;
		end else begin
			top_new = d;
		end

		jmp_pc = pc_q + imm_q + 32'd2;
		unique case (op)
			OP_JUMP: pc_next = jmp_pc;
			OP_JNE:  pc_next = (top_q != 32'd0) ? jmp_pc : pc_q + 32'd2;
			OP_JE:   pc_next = (top_q == 32'd0) ? jmp_pc : pc_q + 32'd2;
			default: pc_next = len2 ? pc_q + 32'd2 : pc_q + 32'd1;
		endcase
		steps_inc = steps_q + 63'd1;
	end

	always_comb begin
		if (is_mod_q) begin
			usub = 1'b1;
			ux   = {1'b0, acc_q, ma_q[31]};
			uy   = {2'b00, mb_q};
		end else begin
			usub = 1'b0;
			ux   = {2'b00, acc_q};
			uy   = mb_q[0] ? {2'b00, ma_q} : 34'd0;
		end
		usum = ux + (usub ? ~uy : uy) + {33'd0, usub};
		if (!is_mod_q) begin
			iter_next = usum[31:0];
		end else if (!usum[33]) begin
			iter_next = usum[31:0];
		end else begin
			iter_next = ux[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= '1;
			steps_q     <= '0;
			pc_q        <= '0;
			mstate_q    <= RS_RUN;
			count_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			widx_q      <= '0;
			pushn_q     <= '0;
			it_q        <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[7:0];
						imm_q   <= s_tdata[39:8];
						rnd_q   <= s_tdata[71:40];
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					b_q     <= rdata_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					printed_q <= active && (op == OP_PRINT) && !unf;
					pval_q    <= top_q;
					count_q   <= count_new;
					wbase_q   <= c1;
					pushn_q   <= push_done;
					widx_q    <= '0;
					v_q[0]    <= v0;
					v_q[1]    <= v1;
					v_q[2]    <= v2;
					acc_q     <= '0;
					ma_q      <= top_q;
					mb_q      <= b_q;
					is_mod_q  <= (op == OP_MOD);
					it_q      <= '0;
					if (!use_iter) begin
						top_q <= top_new;
					end
					if (!running) begin
						cause_q <= SC_NONE;
					end else if (at_limit) begin
						cause_q <= SC_LIMIT;
					end else if (fault) begin
						mstate_q <= RS_BRK;
						if (range_f) begin
							cause_q <= SC_PC;
						end else if (unf) begin
							cause_q <= SC_UNF;
						end else if (zdiv) begin
							cause_q <= SC_ZDIV;
						end else begin
							cause_q <= SC_OVF;
						end
					end else begin
						pc_q    <= pc_next;
						steps_q <= steps_inc;
						if (op == OP_BREAK) begin
							mstate_q <= RS_BRK;
							cause_q  <= SC_BRK;
						end else if (op == OP_HALT) begin
							mstate_q <= RS_HALT;
							cause_q  <= SC_HALT;
						end else if (steps_inc >= limit_q) begin
							cause_q <= SC_LIMIT;
						end else begin
							cause_q <= SC_NONE;
						end
					end
					state_q <= use_iter ? ST_ITER : ST_WR;
				end
				ST_ITER: begin
					acc_q <= iter_next;
					ma_q  <= {ma_q[30:0], 1'b0};
					if (!is_mod_q) begin
						mb_q <= {1'b0, mb_q[31:1]};
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						v_q[0]  <= iter_next;
						top_q   <= iter_next;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (widx_q < pushn_q) begin
						widx_q <= widx_q + 2'd1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
			out_user_q <= printed_q;
			out_data_q <= {5'd0, steps_q, (printed_q ? pval_q : 32'd0), top_q,
				cnt_ext[6:0], cause_q, mstate_q, pc_q};
		end
	end

endmodule

`default_nettype wire

/* tb/tb_stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// tb_stack_machine_executor_unit
// self-checking bench for the stack machine executor: a directed instruction
// table, then legal random programs over several step limits with random
// stalls on both streams, ending in one stop condition picked at random.
// every result is compared with a fixed expected value or an in-bench model of the machine
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_machine_executor_unit
	import smx_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     STACK_MAX    = 64;
	localparam int     PROG_WORDS   = 512;
	localparam int     PC_FOLD      = 480;
	localparam int     DRAIN_CYCLES = 48;
	localparam int     LONG_HOLD    = 300;
	localparam int     IDLE_LIMIT   = 5000;
	localparam int     SEG_ITEMS    = 140;
	localparam steps_t LIMIT_MAX    = {63{1'b1}};

	typedef struct packed {
		word_t       random_word;
		word_t       immediate;
		logic [7:0]  opcode;
	} instr_t;

	typedef struct packed {
		steps_t      executed_steps;
		word_t       print_value;
		word_t       top_value;
		logic [6:0]  stack_depth;
		logic [2:0]  stop_cause;
		logic [1:0]  run_state;
		word_t       next_pc;
		logic        print_valid;
	} result_t;

	typedef struct {
		instr_t  instr;
		bit      fixed;
		result_t want;
	} dir_row_t;

	typedef enum {
		END_OVERFLOW, END_UNDERFLOW, END_ZERO_DIV, END_PC_RANGE,
		END_BREAK, END_UNDEFINED, END_HALT
	} stop_kind_e;

	logic          clk;
	logic          arst_n;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [62:0]   cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [71:0]   s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [175:0]  m_tdata;
	logic          m_tuser;

	stack_machine_executor_unit #(
		.STACK_DEPTH   (STACK_MAX),
		.PROGRAM_WORDS (PROG_WORDS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// machine model
	word_t      mach_stack [STACK_MAX];
	int         mach_depth;
	word_t      mach_pc;
	logic [1:0] mach_state;
	steps_t     mach_steps;
	steps_t     mach_limit;
	bit         step_fault;
	logic [2:0] step_cause;

	result_t    pending_results [$];
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         depth_goal;
	bit         no_idle;
	bit         long_hold_req;
	bit         long_hold_done = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic instr_t mk(logic [7:0] op, word_t imm, word_t rnd);
		return '{random_word: rnd, immediate: imm, opcode: op};
	endfunction

	function automatic result_t mk_result(word_t pc, logic [1:0] st, logic [2:0] cause,
			logic [6:0] depth, word_t top, steps_t steps);
		return '{executed_steps: steps, print_value: '0, top_value: top,
			stack_depth: depth, stop_cause: cause, run_state: st, next_pc: pc,
			print_valid: 1'b0};
	endfunction

	function automatic void push_word(word_t v);
		if (step_fault)
			return;
		if (mach_depth >= STACK_MAX) begin
			step_fault = 1'b1;
			step_cause = SC_OVF;
			return;
		end
		mach_stack[mach_depth] = v;
		mach_depth++;
	endfunction

	function automatic word_t pop_word();
		if (step_fault)
			return '0;
		if (mach_depth == 0) begin
			step_fault = 1'b1;
			step_cause = SC_UNF;
			return '0;
		end
		mach_depth--;
		return mach_stack[mach_depth];
	endfunction

	function automatic result_t execute_instruction(instr_t it);
		result_t    r;
		logic [7:0] op;
		word_t      a, b, new_pc, pv;
		bit         printed;
		int         len;
		step_fault = 1'b0;
		step_cause = SC_NONE;
		pv = '0;
		printed = 1'b0;
		op = (it.opcode > OP_JUMP) ? OP_BREAK : it.opcode;
		len = (op inside {OP_PUSH, OP_JNE, OP_JE, OP_JUMP}) ? 2 : 1;
		if (mach_state != RS_RUN) begin
			step_cause = SC_NONE;
		end else if (mach_steps >= mach_limit) begin
			step_cause = SC_LIMIT;
		end else begin
			if (mach_pc >= PROG_WORDS || (len == 2 && mach_pc + 32'd1 >= PROG_WORDS)) begin
				step_fault = 1'b1;
				step_cause = SC_PC;
			end else begin
				new_pc = mach_pc + word_t'(len);
				case (op)
					OP_BREAK: begin
						mach_state = RS_BRK;
						step_cause = SC_BRK;
					end
					OP_NOP: ;
					OP_HALT: begin
						mach_state = RS_HALT;
						step_cause = SC_HALT;
					end
					OP_PUSH: push_word(it.immediate);
					OP_PRINT: begin
						pv = pop_word();
						printed = !step_fault;
					end
					OP_JNE: begin
						a = pop_word();
						if (a != 0)
							new_pc = mach_pc + it.immediate + 32'd2;
					end
					OP_SWAP: begin
						a = pop_word();
						b = pop_word();
						push_word(a);
						push_word(b);
					end
					OP_DUP: begin
						a = pop_word();
						push_word(a);
						push_word(a);
					end
					OP_JE: begin
						a = pop_word();
						if (a == 0)
							new_pc = mach_pc + it.immediate + 32'd2;
					end
					OP_INC: begin
						a = pop_word();
						push_word(a + 32'd1);
					end
					OP_ADD: begin
						a = pop_word();
						b = pop_word();
						push_word(a + b);
					end
					OP_SUB: begin
						a = pop_word();
						b = pop_word();
						push_word(a - b);
					end
					OP_MUL: begin
						a = pop_word();
						b = pop_word();
						push_word(a * b);
					end
					OP_RAND: push_word(it.random_word);
					OP_DEC: begin
						a = pop_word();
						push_word(a - 32'd1);
					end
					OP_DROP: a = pop_word();
					OP_OVER: begin
						a = pop_word();
						b = pop_word();
						push_word(b);
						push_word(a);
						push_word(b);
					end
					OP_MOD: begin
						a = pop_word();
						b = pop_word();
						if (!step_fault && b == 0) begin
							step_fault = 1'b1;
							step_cause = SC_ZDIV;
						end
						if (!step_fault)
							push_word(a % b);
					end
					default: new_pc = mach_pc + it.immediate + 32'd2;
				endcase
				if (!step_fault) begin
					mach_pc = new_pc;
					mach_steps = mach_steps + 63'd1;
					if (mach_state == RS_RUN && mach_steps >= mach_limit)
						step_cause = SC_LIMIT;
				end
			end
			if (step_fault) begin
				mach_state = RS_BRK;
				printed = 1'b0;
				pv = '0;
			end
		end
		r.next_pc = mach_pc;
		r.run_state = mach_state;
		r.stop_cause = step_cause;
		r.stack_depth = 7'(mach_depth);
		r.top_value = (mach_depth > 0) ? mach_stack[mach_depth - 1] : '0;
		r.print_valid = printed;
		r.print_value = printed ? pv : '0;
		r.executed_steps = mach_steps;
		return r;
	endfunction

	function automatic bit is_legal(logic [7:0] op);
		case (op)
			OP_NOP, OP_JUMP:             return 1'b1;
			OP_PUSH, OP_RAND:            return mach_depth < STACK_MAX;
			OP_PRINT, OP_JNE, OP_JE,
			OP_INC, OP_DEC, OP_DROP:     return mach_depth >= 1;
			OP_DUP:                      return mach_depth >= 1 && mach_depth < STACK_MAX;
			OP_SWAP, OP_ADD, OP_SUB,
			OP_MUL:                      return mach_depth >= 2;
			OP_OVER:                     return mach_depth >= 2 && mach_depth < STACK_MAX;
			OP_MOD:                      return mach_depth >= 2 &&
			                                    mach_stack[mach_depth - 2] != 0;
			default:                     return 1'b0;
		endcase
	endfunction

	// random instruction that keeps the machine running and pc in range
	function automatic instr_t pick_instr();
		logic [7:0] op;
		word_t      imm, target;
		bit         taken;
		imm = $urandom();
		if ($urandom_range(0, 3) == 0)
			imm = $urandom_range(0, 15);
		target = $urandom_range(0, PC_FOLD - 1);
		if ($urandom_range(0, 31) == 0) begin
			case ($urandom_range(0, 3))
				0:       depth_goal = 0;
				1:       depth_goal = STACK_MAX;
				default: depth_goal = $urandom_range(0, STACK_MAX);
			endcase
		end
		if (mach_pc >= PC_FOLD) begin
			op = OP_JUMP;
		end else begin
			do begin
				if (mach_depth < depth_goal && $urandom_range(0, 1)) begin
					case ($urandom_range(0, 3))
						0:       op = OP_PUSH;
						1:       op = OP_RAND;
						2:       op = OP_DUP;
						default: op = OP_OVER;
					endcase
				end else if (mach_depth > depth_goal && $urandom_range(0, 1)) begin
					case ($urandom_range(0, 3))
						0:       op = OP_DROP;
						1:       op = OP_PRINT;
						2:       op = OP_ADD;
						default: op = OP_MUL;
					endcase
				end else begin
					op = 8'($urandom_range(OP_NOP, OP_JUMP));
				end
			end while (!is_legal(op));
		end
		taken = (op == OP_JUMP) ||
			(op == OP_JNE && mach_stack[mach_depth - 1] != 0) ||
			(op == OP_JE && mach_stack[mach_depth - 1] == 0);
		if (taken)
			imm = target - mach_pc - 32'd2;
		return mk(op, imm, $urandom());
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic string fmt_result(result_t r);
		return $sformatf("pc=%0h st=%0d cause=%0d depth=%0d top=%0h print=%0b/%0h steps=%0d",
			r.next_pc, r.run_state, r.stop_cause, r.stack_depth, r.top_value,
			r.print_valid, r.print_value, r.executed_steps);
	endfunction

	task automatic drive_item(instr_t it, bit fixed, result_t want);
		int      gap;
		result_t r;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = execute_instruction(it);
		pending_results.push_back(fixed ? want : r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(steps_t v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mach_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_segment(int n_exec, bit with_hold);
		int done;
		done = 0;
		while (done < n_exec && mach_steps < mach_limit) begin
			if (with_hold && done == 10)
				long_hold_req = 1'b1;
			drive_item(pick_instr(), 1'b0, '0);
			done++;
		end
		if (mach_steps >= mach_limit)
			repeat (3) drive_item(mk(8'($urandom_range(0, 255)), $urandom(), $urandom()),
				1'b0, '0);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		result_t got_r, want_r;
		if (arst_n && m_tvalid && m_tready) begin
			got_r = {m_tdata[170:0], m_tuser};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t mismatch: unexpected result %s", $realtime,
						fmt_result(got_r));
			end else begin
				want_r = pending_results.pop_front();
				if (got_r !== want_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t mismatch:\n  exp %s\n  got %s", $realtime,
							fmt_result(want_r), fmt_result(got_r));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (quiet_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("[stack_machine_executor_unit] ERROR");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		dir_row_t   dir_rows [$];
		stop_kind_e finale;
		steps_t     seg_limit;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		depth_goal = 8;
		no_idle = 1'b0;
		long_hold_req = 1'b0;
		mach_depth = 0;
		mach_pc = '0;
		mach_state = RS_RUN;
		mach_steps = '0;
		mach_limit = LIMIT_MAX;

		dir_rows.push_back('{mk(OP_PUSH, 32'h7FFFFFFF, 32'h0), 1'b1,
			mk_result(32'd2, RS_RUN, SC_NONE, 7'd1, 32'h7FFFFFFF, 63'd1)});
		dir_rows.push_back('{mk(OP_PUSH, 32'h80000000, 32'h0), 1'b1,
			mk_result(32'd4, RS_RUN, SC_NONE, 7'd2, 32'h80000000, 63'd2)});
		dir_rows.push_back('{mk(OP_ADD, 32'h0, 32'h0), 1'b1,
			mk_result(32'd5, RS_RUN, SC_NONE, 7'd1, 32'hFFFFFFFF, 63'd3)});
		dir_rows.push_back('{mk(OP_INC, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_DEC, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_DUP, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_MUL, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_RAND, 32'h0, 32'hFFFFFFFF), 1'b0, '0});
		dir_rows.push_back('{mk(OP_SWAP, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_OVER, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_SUB, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_PUSH, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_JNE, 32'h80000000, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_PUSH, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_JE, 32'd10, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_PUSH, 32'd1, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_JNE, 32'hFFFFFFFB, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_JUMP, 32'd100, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_PUSH, 32'd3, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_PUSH, 32'hFFFFFFFF, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_MOD, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_PRINT, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_DROP, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_NOP, 32'h0, 32'h0), 1'b0, '0});
		dir_rows.push_back('{mk(OP_JUMP, 32'hFFFFFFCE, 32'h0), 1'b0, '0});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero step limit: nothing executes
		write_limit('0);
		drive_item(mk(OP_NOP, 32'h0, 32'h0), 1'b1,
			mk_result(32'd0, RS_RUN, SC_LIMIT, 7'd0, 32'h0, 63'd0));
		drive_item(mk(OP_PUSH, 32'd5, 32'h0), 1'b1,
			mk_result(32'd0, RS_RUN, SC_LIMIT, 7'd0, 32'h0, 63'd0));
		wait_drained();
		write_limit(LIMIT_MAX);

		foreach (dir_rows[i])
			drive_item(dir_rows[i].instr, dir_rows[i].fixed, dir_rows[i].want);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				2:       seg_limit = mach_steps + 63'($urandom_range(20, 100));
				4:       seg_limit = mach_steps;
				5:       seg_limit = mach_steps + 63'($urandom_range(50, 150));
				default: seg_limit = LIMIT_MAX;
			endcase
			wait_drained();
			write_limit(seg_limit);
			no_idle = (seg == 3);
			run_segment(SEG_ITEMS, seg == 1);
		end
		no_idle = 1'b0;

		// one stop condition per run, then items that must change nothing
		wait_drained();
		write_limit(LIMIT_MAX);
		drive_item(mk(OP_JUMP, 32'd0 - mach_pc - 32'd2, $urandom()), 1'b0, '0);
		finale = stop_kind_e'($urandom_range(0, 6));
		case (finale)
			END_OVERFLOW: begin
				while (mach_depth < STACK_MAX)
					drive_item(mk(OP_PUSH, $urandom(), $urandom()), 1'b0, '0);
				drive_item(mk(OP_PUSH, $urandom(), $urandom()), 1'b0, '0);
			end
			END_UNDERFLOW: begin
				while (mach_depth > 0)
					drive_item(mk(OP_DROP, $urandom(), $urandom()), 1'b0, '0);
				drive_item(mk(OP_PRINT, $urandom(), $urandom()), 1'b0, '0);
			end
			END_ZERO_DIV: begin
				drive_item(mk(OP_PUSH, 32'h0, $urandom()), 1'b0, '0);
				drive_item(mk(OP_PUSH, $urandom(), $urandom()), 1'b0, '0);
				drive_item(mk(OP_MOD, $urandom(), $urandom()), 1'b0, '0);
			end
			END_PC_RANGE: begin
				drive_item(mk(OP_JUMP, 32'd511 - mach_pc - 32'd2, $urandom()), 1'b0, '0);
				drive_item(mk(OP_PUSH, $urandom(), $urandom()), 1'b0, '0);
			end
			END_BREAK:
				drive_item(mk(OP_BREAK, $urandom(), $urandom()), 1'b0, '0);
			END_UNDEFINED:
				drive_item(mk(8'($urandom_range(OP_JUMP + 1, 255)), $urandom(), $urandom()),
					1'b0, '0);
			default:
				drive_item(mk(OP_HALT, $urandom(), $urandom()), 1'b0, '0);
		endcase
		repeat (30)
			drive_item(mk(8'($urandom_range(0, 255)), $urandom(), $urandom()), 1'b0, '0);

		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[stack_machine_executor_unit] OK");
		else
			$display("[stack_machine_executor_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
